// File: src/mcr_pkg.sv
`default_nettype none
package mcr_pkg;

    localparam int RADIUS_W   = 4;
    localparam int STEP_W     = 4;
    localparam int DEC_W      = 8;
    localparam int PIX_W      = 12;
    localparam int OCT_W      = 3;
    localparam int MAX_RADIUS = 8;

    localparam logic [OCT_W-1:0]        OCT_LAST = OCT_W'(7);
    localparam logic signed [DEC_W-1:0] D_INIT   = DEC_W'(3);
    localparam logic signed [DEC_W-1:0] D_INC_X  = DEC_W'(6);
    localparam logic signed [DEC_W-1:0] D_INC_XY = DEC_W'(10);

    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } mcr_state_t;

    // controller -> datapath
    typedef struct packed
    {
        logic load;   // take a new circle
        logic emit;   // register current pixel, advance octant walk
    } mcr_cmd_t;

    // datapath -> controller
    typedef struct packed
    {
        logic last;   // current pixel ends the run
    } mcr_sts_t;

endpackage
`default_nettype wire

// File: src/mcr_in_if.sv
`default_nettype none
interface mcr_in_if #(
    parameter int COORD_BITS = 10
);
    logic                          valid;
    logic                          ready;
    logic [COORD_BITS-1:0]         center_x;
    logic [COORD_BITS-1:0]         center_y;
    logic [mcr_pkg::RADIUS_W-1:0]  radius;

    modport source (output valid, output center_x, output center_y, output radius,
                    input ready);
    modport sink   (input valid, input center_x, input center_y, input radius,
                    output ready);
endinterface
`default_nettype wire

// File: src/mcr_out_if.sv
`default_nettype none
interface mcr_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [mcr_pkg::PIX_W-1:0] pixel_x;
    logic signed [mcr_pkg::PIX_W-1:0] pixel_y;
    logic                             last_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output last_pixel,
                    input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input last_pixel,
                    output ready);
endinterface
`default_nettype wire

// File: src/mcr_ctrl.sv
`default_nettype none
module mcr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output mcr_pkg::mcr_cmd_t      cmd,
    input  wire mcr_pkg::mcr_sts_t sts
);

    mcr_pkg::mcr_state_t state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic                can_emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mcr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output slot is free or being drained this cycle
    assign can_emit = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            mcr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = mcr_pkg::ST_RUN;
                end
            end
            mcr_pkg::ST_RUN:
            begin
                if (can_emit)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    if (sts.last)
                        state_next = mcr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mcr_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    // a loaded circle always starts a run
    a_load_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == mcr_pkg::ST_RUN)
        else $error("load did not enter run");

    // never overwrite a pixel still waiting downstream
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("pixel overwritten");

    // final pixel leaves the block idle with that pixel presented
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && sts.last) |=> (state_reg == mcr_pkg::ST_IDLE && out_valid_reg))
        else $error("run did not close on last pixel");

endmodule
`default_nettype wire

// File: src/mcr_dpath.sv
`default_nettype none
module mcr_dpath #(
    parameter int COORD_BITS = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire mcr_pkg::mcr_cmd_t                 cmd,
    output mcr_pkg::mcr_sts_t                      sts,
    input  wire logic [COORD_BITS-1:0]             center_x,
    input  wire logic [COORD_BITS-1:0]             center_y,
    input  wire logic [mcr_pkg::RADIUS_W-1:0]      radius,
    output logic signed [mcr_pkg::PIX_W-1:0]       pixel_x,
    output logic signed [mcr_pkg::PIX_W-1:0]       pixel_y,
    output logic                                   last_pixel
);

    localparam int EXT_W = (COORD_BITS > mcr_pkg::PIX_W) ? COORD_BITS : mcr_pkg::PIX_W;

    logic [mcr_pkg::PIX_W-1:0]          cx_reg, cy_reg;
    logic [mcr_pkg::STEP_W-1:0]         x_reg, y_reg;
    logic signed [mcr_pkg::DEC_W-1:0]   d_reg, d_next;
    logic [mcr_pkg::OCT_W-1:0]          oct_reg;
    logic [mcr_pkg::PIX_W-1:0]          px_reg, py_reg;
    logic                               last_reg;

    logic [mcr_pkg::STEP_W-1:0]         r_sat;
    logic [mcr_pkg::STEP_W-1:0]         a_val, b_val;
    logic [mcr_pkg::PIX_W-1:0]          a_ext, b_ext, px_next, py_next;
    logic signed [mcr_pkg::DEC_W-1:0]   x4, xy4;
    logic                               d_neg, last_now;

    assign r_sat = (radius > mcr_pkg::RADIUS_W'(mcr_pkg::MAX_RADIUS))
                 ? mcr_pkg::STEP_W'(mcr_pkg::MAX_RADIUS) : radius;

    // octant point mirror: bit0 swaps x/y, bit1 picks +/- column, bit2 +/- row
    assign a_val   = oct_reg[0] ? y_reg : x_reg;
    assign b_val   = oct_reg[0] ? x_reg : y_reg;
    assign a_ext   = mcr_pkg::PIX_W'(a_val);
    assign b_ext   = mcr_pkg::PIX_W'(b_val);
    assign px_next = oct_reg[1] ? (cx_reg + a_ext) : (cx_reg - a_ext);
    assign py_next = oct_reg[2] ? (cy_reg + b_ext) : (cy_reg - b_ext);

    // decision update
    assign d_neg = d_reg[mcr_pkg::DEC_W-1];
    assign x4    = mcr_pkg::DEC_W'({x_reg, 2'b00});
    assign xy4   = mcr_pkg::DEC_W'({x_reg, 2'b00}) - mcr_pkg::DEC_W'({y_reg, 2'b00});
    assign d_next = d_neg ? (d_reg + x4 + mcr_pkg::D_INC_X)
                          : (d_reg + xy4 + mcr_pkg::D_INC_XY);

    // walk ends when the updated y falls below the updated x
    always_comb
    begin
        if (d_neg)
            last_now = (y_reg <= x_reg);
        else
            last_now = ({1'b0, y_reg} <= ({1'b0, x_reg} + 5'd1));
    end

    assign sts.last = (oct_reg == mcr_pkg::OCT_LAST) && last_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg   <= '0;
            cy_reg   <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            d_reg    <= '0;
            oct_reg  <= '0;
            px_reg   <= '0;
            py_reg   <= '0;
            last_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            cx_reg  <= mcr_pkg::PIX_W'(EXT_W'(center_x));
            cy_reg  <= mcr_pkg::PIX_W'(EXT_W'(center_y));
            x_reg   <= '0;
            y_reg   <= r_sat;
            d_reg   <= mcr_pkg::D_INIT - mcr_pkg::DEC_W'({r_sat, 1'b0});
            oct_reg <= '0;
        end
        else if (cmd.emit)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            last_reg <= sts.last;
            oct_reg  <= oct_reg + mcr_pkg::OCT_W'(1);
            if (oct_reg == mcr_pkg::OCT_LAST)
            begin
                d_reg <= d_next;
                x_reg <= x_reg + mcr_pkg::STEP_W'(1);
                if (!d_neg && (y_reg != '0))
                    y_reg <= y_reg - mcr_pkg::STEP_W'(1);
            end
        end
    end

    assign pixel_x    = px_reg;
    assign pixel_y    = py_reg;
    assign last_pixel = last_reg;

endmodule
`default_nettype wire

// File: src/midpoint_circle_rasterizer_top.sv
`default_nettype none
// The first pixel word is registered in RUN, after IDLE takes the circle word.
// Throughput: one pixel word per cycle while the sink keeps up; a circle of radius r
//   yields 8 words per octant step, up to 48 words at radius 8.
// The next circle word is taken the cycle after the last pixel word is registered;
//   the final pixel may still be waiting downstream at that time.
// Reset (rst_n low, async): controller idle, walk registers zero, no pixel word pending.
module midpoint_circle_rasterizer_top #(
    parameter int COORD_BITS = 10
) (
    input wire logic clk,
    input wire logic rst_n,
    mcr_in_if.sink   in_ch,
    mcr_out_if.source out_ch
);

    mcr_pkg::mcr_cmd_t cmd;
    mcr_pkg::mcr_sts_t sts;

    // Controller: IDLE takes a circle word, RUN emits one pixel word per free
    // output slot and returns to IDLE on the flagged final pixel.
    mcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Datapath: center/radius capture, octant walk registers (x, y, decision,
    // octant index), eight-way mirror and the output pixel register.
    mcr_dpath #(
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .center_x   (in_ch.center_x),
        .center_y   (in_ch.center_y),
        .radius     (in_ch.radius),
        .pixel_x    (out_ch.pixel_x),
        .pixel_y    (out_ch.pixel_y),
        .last_pixel (out_ch.last_pixel)
    );

endmodule
`default_nettype wire

// File: tb/sv/tb_midpoint_circle_rasterizer_top.sv
`default_nettype none
module tb_midpoint_circle_rasterizer_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CBITS      = 10;
    localparam int DIRECTED_N = 22;
    localparam int RANDOM_N   = 308;
    localparam int CALM_TAIL  = 40;     // last circles run with no idling on either side
    localparam int MAX_WORDS  = 64;     // words one circle may ever produce
    localparam int SHOW_MAX   = 10;     // failures printed in full

    // One expected pixel word, laid out like the output channel payload.
    typedef struct packed
    {
        logic [mcr_pkg::PIX_W-1:0] pixel_x;
        logic [mcr_pkg::PIX_W-1:0] pixel_y;
        logic                      last_pixel;
    } circle_pixel_t;

    // One directed circle. For a zero radius the answer is plain: eight copies
    // of the centre, so it is typed in (centre_only, cen_x, cen_y) rather than
    // predicted. All other rows go through the predictor.
    typedef struct packed
    {
        logic [CBITS-1:0]             cx;
        logic [CBITS-1:0]             cy;
        logic [mcr_pkg::RADIUS_W-1:0] rad;
        logic                         centre_only;
        logic [mcr_pkg::PIX_W-1:0]    cen_x;
        logic [mcr_pkg::PIX_W-1:0]    cen_y;
    } circle_row_t;

    circle_row_t directed_rows [0:DIRECTED_N-1] = '{
        // zero radius: single step, centre pixel eight times
        '{10'd0,    10'd0,    4'd0,  1'b1, 12'd0,    12'd0},
        '{10'd1023, 10'd1023, 4'd0,  1'b1, 12'd1023, 12'd1023},
        '{10'd512,  10'd1,    4'd0,  1'b1, 12'd512,  12'd1},
        // smallest circle on both corners: pixels wrap below zero, pass 1023
        '{10'd0,    10'd0,    4'd1,  1'b0, 12'd0,    12'd0},
        '{10'd1023, 10'd1023, 4'd1,  1'b0, 12'd0,    12'd0},
        // every legal radius, diagonal and axis duplicates included
        '{10'd500,  10'd300,  4'd1,  1'b0, 12'd0,    12'd0},
        '{10'd500,  10'd300,  4'd2,  1'b0, 12'd0,    12'd0},
        '{10'd100,  10'd900,  4'd3,  1'b0, 12'd0,    12'd0},
        '{10'd900,  10'd100,  4'd4,  1'b0, 12'd0,    12'd0},
        '{10'd256,  10'd768,  4'd5,  1'b0, 12'd0,    12'd0},
        '{10'd768,  10'd256,  4'd6,  1'b0, 12'd0,    12'd0},
        '{10'd31,   10'd992,  4'd7,  1'b0, 12'd0,    12'd0},
        '{10'd500,  10'd300,  4'd8,  1'b0, 12'd0,    12'd0},
        // largest radius at all four corners of the field
        '{10'd0,    10'd0,    4'd8,  1'b0, 12'd0,    12'd0},
        '{10'd1023, 10'd0,    4'd8,  1'b0, 12'd0,    12'd0},
        '{10'd0,    10'd1023, 4'd8,  1'b0, 12'd0,    12'd0},
        '{10'd1023, 10'd1023, 4'd8,  1'b0, 12'd0,    12'd0},
        // radius above the maximum saturates
        '{10'd600,  10'd600,  4'd9,  1'b0, 12'd0,    12'd0},
        '{10'd0,    10'd0,    4'd15, 1'b0, 12'd0,    12'd0},
        '{10'd1023, 10'd1023, 4'd15, 1'b0, 12'd0,    12'd0},
        // alternating bit patterns on the centre fields
        '{10'd341,  10'd682,  4'd12, 1'b0, 12'd0,    12'd0},
        '{10'd682,  10'd341,  4'd3,  1'b0, 12'd0,    12'd0}
    };

    logic clk = 1'b0;
    logic rst_n;

    mcr_in_if #(.COORD_BITS(CBITS)) in_ch ();
    mcr_out_if                      out_ch ();

    midpoint_circle_rasterizer_top #(.COORD_BITS(CBITS)) dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    circle_pixel_t expected_pixels [$];   // words still owed by the block, oldest first
    int  fail_count    = 0;
    int  words_checked = 0;
    int  circles_sent  = 0;
    int  zero_radius_n = 0;
    int  saturated_n   = 0;
    bit  quiet_tail    = 1'b0;            // both sides stop idling near the end

    // Midpoint circle walk: appends every pixel word one circle produces, in
    // the block's octant order, and flags the final one.
    task automatic queue_circle_pixels(input logic [CBITS-1:0] cx,
                                       input logic [CBITS-1:0] cy,
                                       input logic [mcr_pkg::RADIUS_W-1:0] r);
        int rad;
        int ox;
        int oy;
        int dec;
        int a;
        int b;
        int px;
        int py;
        int n;
        bit have;
        circle_pixel_t held;
        rad  = (r > mcr_pkg::MAX_RADIUS) ? mcr_pkg::MAX_RADIUS : int'(r);
        ox   = 0;
        oy   = rad;
        dec  = int'(mcr_pkg::D_INIT) - 2 * rad;
        n    = 0;
        have = 1'b0;
        held = '0;
        while (oy >= ox && n + 8 <= MAX_WORDS)
        begin
            for (int oct = 0; oct <= int'(mcr_pkg::OCT_LAST); oct++)
            begin
                // odd octants swap x and y; bit 1 mirrors columns, bit 2 rows
                a  = oct[0] ? oy : ox;
                b  = oct[0] ? ox : oy;
                px = oct[1] ? int'(cx) + a : int'(cx) - a;
                py = oct[2] ? int'(cy) + b : int'(cy) - b;
                if (have)
                    expected_pixels.push_back(held);
                held.pixel_x    = px[mcr_pkg::PIX_W-1:0];
                held.pixel_y    = py[mcr_pkg::PIX_W-1:0];
                held.last_pixel = 1'b0;
                have = 1'b1;
                n++;
            end
            if (dec < 0)
            begin
                dec = dec + 4 * ox + int'(mcr_pkg::D_INC_X);
                ox++;
            end
            else
            begin
                dec = dec + 4 * (ox - oy) + int'(mcr_pkg::D_INC_XY);
                ox++;
                if (oy == 0)
                    break;
                oy--;
            end
        end
        held.last_pixel = 1'b1;
        expected_pixels.push_back(held);
    endtask

    // centre close to one end of the coordinate range
    function automatic logic [CBITS-1:0] near_edge();
        if ($urandom_range(0, 1) == 0)
            return CBITS'($urandom_range(0, 8));
        return CBITS'(1023 - $urandom_range(0, 8));
    endfunction

    // ------------------------------------------------------------------
    // Circle word driver. Valid stays high across back-to-back words and
    // is only lowered for an idle burst. A word counts as taken at the
    // first edge where valid and ready were both high.
    // ------------------------------------------------------------------
    initial
    begin
        circle_row_t      row;
        logic [CBITS-1:0] cx;
        logic [CBITS-1:0] cy;
        logic [mcr_pkg::RADIUS_W-1:0] rad;
        int  total;
        int  gap;
        int  pick;
        bit  sender_calm;
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.center_x  <= '0;
        in_ch.center_y  <= '0;
        in_ch.radius    <= '0;
        total       = DIRECTED_N + RANDOM_N;
        sender_calm = 1'b0;
        row         = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int k = 0; k < total; k++)
        begin
            if (k < DIRECTED_N)
            begin
                row = directed_rows[k];
                cx  = row.cx;
                cy  = row.cy;
                rad = row.rad;
            end
            else
            begin
                row = '0;
                cx  = ($urandom_range(0, 6) == 0) ? near_edge() : CBITS'($urandom_range(0, 1023));
                cy  = ($urandom_range(0, 6) == 0) ? near_edge() : CBITS'($urandom_range(0, 1023));
                // mostly legal radii, some zero, some above the maximum
                pick = $urandom_range(0, 99);
                if (pick < 7)
                    rad = '0;
                else if (pick < 17)
                    rad = mcr_pkg::RADIUS_W'($urandom_range(9, 15));
                else
                    rad = mcr_pkg::RADIUS_W'($urandom_range(1, mcr_pkg::MAX_RADIUS));
            end

            // sender alternates between calm stretches and gappy stretches
            if (k % 25 == 0)
                sender_calm = ($urandom_range(0, 2) == 0);
            quiet_tail = (k >= total - CALM_TAIL);
            gap = 0;
            if (!quiet_tail && !sender_calm && $urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 19);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end

            in_ch.valid    <= 1'b1;
            in_ch.center_x <= cx;
            in_ch.center_y <= cy;
            in_ch.radius   <= rad;
            do
                @(posedge clk);
            while (!in_ch.ready);

            // taken: record what the block owes for this circle
            if (row.centre_only)
            begin
                for (int i = 0; i < 8; i++)
                    expected_pixels.push_back('{row.cen_x, row.cen_y, (i == 7)});
            end
            else
                queue_circle_pixels(cx, cy, rad);
            circles_sent++;
            if (rad == 0)
                zero_radius_n++;
            if (rad > mcr_pkg::MAX_RADIUS)
                saturated_n++;
        end
        in_ch.valid <= 1'b0;

        // drain, then keep watching to catch any stray extra word
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d circles sent (%0d of radius zero, %0d saturated), %0d pixel words checked",
                 circles_sent, zero_radius_n, saturated_n, words_checked);
        $display("centres at both ends of the range, random sender gaps and sink stalls");
        if (fail_count == 0)
            $display("** midpoint_circle_rasterizer_top: PASSED **");
        else
            $display("** midpoint_circle_rasterizer_top: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Pixel word sink and checker. Ready comes in random runs and
    // stalls; forced high in the calm tail.
    // ------------------------------------------------------------------
    initial
    begin
        circle_pixel_t want;
        int left;
        bit ready_next;
        left         = 0;
        ready_next   = 1'b0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= SHOW_MAX)
                        $display("%0t: pixel word x=%0d y=%0d last=%b with none owed",
                                 $time, out_ch.pixel_x, out_ch.pixel_y, out_ch.last_pixel);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    words_checked++;
                    if (out_ch.pixel_x !== want.pixel_x || out_ch.pixel_y !== want.pixel_y
                        || out_ch.last_pixel !== want.last_pixel)
                    begin
                        fail_count++;
                        if (fail_count <= SHOW_MAX)
                            $display("%0t: word %0d expected x=%0d y=%0d last=%b, got x=%0d y=%0d last=%b",
                                     $time, words_checked, $signed(want.pixel_x),
                                     $signed(want.pixel_y), want.last_pixel, out_ch.pixel_x,
                                     out_ch.pixel_y, out_ch.last_pixel);
                    end
                end
            end

            if (left == 0)
            begin
                if ($urandom_range(0, 9) < 6)
                begin
                    ready_next = 1'b1;
                    left       = $urandom_range(1, 40);
                end
                else
                begin
                    ready_next = 1'b0;
                    left       = $urandom_range(1, 19);
                end
            end
            left--;
            out_ch.ready <= rst_n && (quiet_tail || ready_next);
        end
    end

    // hard stop, far beyond the slowest legal run
    initial
    begin
        #8_000_000;
        $display("timeout with %0d pixel words still owed", expected_pixels.size());
        $display("** midpoint_circle_rasterizer_top: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire
